// ===== rtl/core/spq_pkg.sv =====
// types, constants and helpers shared by the stable priority queue
package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int KEY_W   = 16;
  localparam int PRIO_W  = 4;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;
  localparam int ENTRY_W = KEY_W + PRIO_W;

  localparam logic [PRIO_W-1:0] APPEND_PRIO_RESET = PRIO_W'(3);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_SERVE  = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_PEEK   = 3'd3,
    CMD_COUNT  = 3'd4,
    CMD_DUMP   = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    status_e           status;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
    logic [OCC_W-1:0]  occ;
    logic              last;
  } result_t;

  function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
    return OCC_W'(cnt);
  endfunction

endpackage

// ===== rtl/core/spq_if.sv =====
// channel interfaces of the stable priority queue
interface spq_item_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::CMD_W-1:0]    cmd;
  logic [spq_pkg::KEY_W-1:0]    key;
  logic [spq_pkg::PRIO_W-1:0]   priority_req;

  modport source (output valid, output cmd, output key, output priority_req, input ready);
  modport sink   (input valid, input cmd, input key, input priority_req, output ready);
endinterface

interface spq_result_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::STAT_W-1:0]   status;
  logic [spq_pkg::KEY_W-1:0]    out_key;
  logic [spq_pkg::PRIO_W-1:0]   out_priority;
  logic [spq_pkg::OCC_W-1:0]    occupancy;
  logic                         last;

  modport source (output valid, output status, output out_key, output out_priority,
                  output occupancy, output last, input ready);
  modport sink   (input valid, input status, input out_key, input out_priority,
                  input occupancy, input last, output ready);
endinterface

interface spq_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::PRIO_W-1:0]   append_priority;

  modport source (output valid, output append_priority, input ready);
  modport sink   (input valid, input append_priority, output ready);
endinterface

// ===== rtl/core/spq_ram.sv =====
// generic single write port, single read port ram with registered read data
module spq_ram #(
  parameter int Depth = 16,
  parameter int Width = 20,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/spq_ctrl.sv =====
// command sequencer: walks the entry memory to insert, remove, report and dump
module spq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  spq_item_if.sink                    item_i,
  input  logic [spq_pkg::PRIO_W-1:0]  append_prio_i,
  input  logic                        out_free_i,
  output logic                        res_valid_o,
  output spq_pkg::result_t            res_o,
  output spq_pkg::ram_req_t           ram_o,
  input  spq_pkg::entry_t             ram_rdata_i
);

  spq_pkg::state_e                state_q, state_d;
  spq_pkg::cmd_e                  cmd_q, cmd_d;
  logic [spq_pkg::KEY_W-1:0]      key_q, key_d;
  logic [spq_pkg::PRIO_W-1:0]     prio_q, prio_d;
  logic [spq_pkg::CNT_W-1:0]      count_q, count_d;
  logic [spq_pkg::CNT_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [spq_pkg::CNT_W-1:0]      limit_q, limit_d;
  logic                           vld_q, vld_d;
  logic [spq_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic                           found_q, found_d;
  spq_pkg::entry_t                carry_q, carry_d;
  spq_pkg::result_t               resp_q, resp_d;

  logic                           accept;
  logic                           stall;
  logic                           del_hit;
  spq_pkg::entry_t                new_entry;
  spq_pkg::cmd_e                  in_cmd;
  logic [spq_pkg::CNT_W-1:0]      count_inc;
  logic [spq_pkg::CNT_W-1:0]      count_dec;

  assign item_i.ready = (state_q == spq_pkg::ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign in_cmd       = spq_pkg::cmd_e'(item_i.cmd);
  assign new_entry    = '{key: key_q, prio: prio_q};
  assign count_inc    = spq_pkg::CNT_W'(count_q + 1'b1);
  assign count_dec    = spq_pkg::CNT_W'(count_q - 1'b1);
  assign stall        = vld_q && (cmd_q == spq_pkg::CMD_DUMP) && !out_free_i;
  assign del_hit      = (cmd_q == spq_pkg::CMD_SERVE) ? (idx_q == '0)
                                                      : (ram_rdata_i.key == key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= spq_pkg::ST_IDLE;
      count_q  <= '0;
      rd_ptr_q <= '0;
      vld_q    <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      vld_q    <= vld_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    key_q   <= key_d;
    prio_q  <= prio_d;
    limit_q <= limit_d;
    idx_q   <= idx_d;
    carry_q <= carry_d;
    resp_q  <= resp_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    prio_d      = prio_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    limit_d     = limit_q;
    vld_d       = vld_q;
    idx_d       = idx_q;
    found_d     = found_q;
    carry_d     = carry_q;
    resp_d      = resp_q;
    ram_o       = '0;
    res_valid_o = 1'b0;
    res_o       = resp_q;

    case (state_q)
      spq_pkg::ST_IDLE: begin
        vld_d = 1'b0;
        if (accept) begin
          cmd_d         = in_cmd;
          key_d         = item_i.key;
          prio_d        = item_i.priority_req;
          rd_ptr_d      = '0;
          found_d       = 1'b0;
          limit_d       = count_q;
          resp_d.status = spq_pkg::STAT_OK;
          resp_d.key    = '0;
          resp_d.prio   = '0;
          resp_d.occ    = spq_pkg::occ_of(count_q);
          resp_d.last   = 1'b1;
          case (in_cmd)
            spq_pkg::CMD_ADD: begin
              if (count_q == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
                resp_d.status = spq_pkg::STAT_FULL;
                state_d       = spq_pkg::ST_RESP;
              end else begin
                state_d = spq_pkg::ST_SCAN;
              end
            end
            spq_pkg::CMD_SERVE, spq_pkg::CMD_DELETE, spq_pkg::CMD_DUMP,
            spq_pkg::CMD_PEEK: begin
              if (in_cmd == spq_pkg::CMD_PEEK) begin
                limit_d = spq_pkg::CNT_W'(1);
              end
              if (count_q == '0) begin
                resp_d.status = spq_pkg::STAT_EMPTY;
                state_d       = spq_pkg::ST_RESP;
              end else begin
                state_d = spq_pkg::ST_SCAN;
              end
            end
            default: begin
              state_d = spq_pkg::ST_RESP;
            end
          endcase
        end
      end

      spq_pkg::ST_SCAN: begin
        if (!vld_q && (rd_ptr_q >= limit_q)) begin
          // walk finished, commit the operation
          case (cmd_q)
            spq_pkg::CMD_ADD: begin
              ram_o.we    = 1'b1;
              ram_o.waddr = count_q[spq_pkg::IDX_W-1:0];
              ram_o.wdata = found_q ? carry_q : new_entry;
              count_d     = count_inc;
              resp_d.occ  = spq_pkg::occ_of(count_inc);
              state_d     = spq_pkg::ST_RESP;
            end
            spq_pkg::CMD_SERVE, spq_pkg::CMD_DELETE: begin
              if (found_q) begin
                count_d     = count_dec;
                resp_d.occ  = spq_pkg::occ_of(count_dec);
                resp_d.key  = carry_q.key;
                resp_d.prio = carry_q.prio;
              end else begin
                resp_d.status = spq_pkg::STAT_NOT_FOUND;
              end
              state_d = spq_pkg::ST_RESP;
            end
            spq_pkg::CMD_PEEK: begin
              resp_d.key  = carry_q.key;
              resp_d.prio = carry_q.prio;
              state_d     = spq_pkg::ST_RESP;
            end
            default: begin
              state_d = spq_pkg::ST_IDLE;
            end
          endcase
        end else if (!stall) begin
          // reads run one entry ahead; writes only touch entries already read
          if (rd_ptr_q < limit_q) begin
            ram_o.re    = 1'b1;
            ram_o.raddr = rd_ptr_q[spq_pkg::IDX_W-1:0];
            rd_ptr_d    = spq_pkg::CNT_W'(rd_ptr_q + 1'b1);
            idx_d       = rd_ptr_q[spq_pkg::IDX_W-1:0];
            vld_d       = 1'b1;
          end else begin
            vld_d = 1'b0;
          end
          if (vld_q) begin
            case (cmd_q)
              spq_pkg::CMD_ADD: begin
                if (found_q) begin
                  ram_o.we    = 1'b1;
                  ram_o.waddr = idx_q;
                  ram_o.wdata = carry_q;
                  carry_d     = ram_rdata_i;
                end else if ((prio_q != append_prio_i) && (ram_rdata_i.prio > prio_q)) begin
                  ram_o.we    = 1'b1;
                  ram_o.waddr = idx_q;
                  ram_o.wdata = new_entry;
                  carry_d     = ram_rdata_i;
                  found_d     = 1'b1;
                end
              end
              spq_pkg::CMD_SERVE, spq_pkg::CMD_DELETE: begin
                if (found_q) begin
                  ram_o.we    = 1'b1;
                  ram_o.waddr = spq_pkg::IDX_W'(idx_q - 1'b1);
                  ram_o.wdata = ram_rdata_i;
                end else if (del_hit) begin
                  found_d = 1'b1;
                  carry_d = ram_rdata_i;
                end
              end
              spq_pkg::CMD_PEEK: begin
                carry_d = ram_rdata_i;
                found_d = 1'b1;
              end
              spq_pkg::CMD_DUMP: begin
                res_valid_o  = 1'b1;
                res_o.status = spq_pkg::STAT_OK;
                res_o.key    = ram_rdata_i.key;
                res_o.prio   = ram_rdata_i.prio;
                res_o.occ    = spq_pkg::occ_of(count_q);
                res_o.last   = (spq_pkg::CNT_W'(idx_q) + 1'b1) == count_q;
              end
              default: begin
              end
            endcase
          end
        end else begin
          // dump transaction waiting on the output register
          res_valid_o  = 1'b1;
          res_o.status = spq_pkg::STAT_OK;
          res_o.key    = ram_rdata_i.key;
          res_o.prio   = ram_rdata_i.prio;
          res_o.occ    = spq_pkg::occ_of(count_q);
          res_o.last   = (spq_pkg::CNT_W'(idx_q) + 1'b1) == count_q;
        end
      end

      spq_pkg::ST_RESP: begin
        res_valid_o = 1'b1;
        if (out_free_i) begin
          state_d = spq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = spq_pkg::ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
    else $error("entry count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_o.we && ram_o.re) |-> (ram_o.waddr != ram_o.raddr))
    else $error("read and write hit the same entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != spq_pkg::ST_SCAN) |=> $stable(count_q))
    else $error("entry count changed outside a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (state_q == spq_pkg::ST_SCAN))
    else $error("read data pending outside a scan");

endmodule

// ===== rtl/core/stable_priority_queue.sv =====
// stable priority queue top level: config register, entry memory and result register
//
// item_i takes one command per transaction: add, serve, delete by key, peek, count
// or dump. result_o returns one transaction per command, or one per stored entry
// for a dump of a non-empty queue, with last set on the final one. cfg_i writes the
// append priority; it is always ready. It must be written only while the queue is
// idle; the block itself does not enforce this. Entries live in a 16-entry memory
// with one write and one registered read port. A command is taken only while the
// sequencer is idle. Count, refused and empty commands go straight to the response
// state. Add, serve and delete walk every stored entry once through the read port,
// shifting entries as they go; peek reads only the first entry. A dump reads each
// entry in turn and loads one result per cycle while the output register is free.
// After the last result enters the output register the sequencer returns to idle,
// for a dump through the commit step of the walk, and then takes the next command.
// When result_o stalls, the output register holds its transaction and the walk
// pauses until it drains. Reset empties the queue and sets the append priority to
// 3; the memory is not cleared, as only entries below the count are ever read.
module stable_priority_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  spq_item_if.sink      item_i,
  spq_result_if.source  result_o,
  spq_cfg_if.sink       cfg_i
);

  logic [spq_pkg::PRIO_W-1:0]  append_prio_q;
  logic                        out_valid_q;
  spq_pkg::result_t            out_q;
  logic                        out_free;
  logic                        res_valid;
  spq_pkg::result_t            res;
  spq_pkg::ram_req_t           ram_req;
  logic [spq_pkg::ENTRY_W-1:0] ram_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      append_prio_q <= spq_pkg::APPEND_PRIO_RESET;
    end else if (cfg_i.valid) begin
      append_prio_q <= cfg_i.append_priority;
    end
  end

  assign out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.status       = out_q.status;
  assign result_o.out_key      = out_q.key;
  assign result_o.out_priority = out_q.prio;
  assign result_o.occupancy    = out_q.occ;
  assign result_o.last         = out_q.last;

  spq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .append_prio_i (append_prio_q),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .ram_o         (ram_req),
    .ram_rdata_i   (spq_pkg::entry_t'(ram_rdata))
  );

  spq_ram #(
    .Depth (spq_pkg::DEPTH),
    .Width (spq_pkg::ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== verif/tb.sv =====
// testbench for the stable priority queue: queue-order predictor, driver and monitor
`timescale 1ns / 100ps

module tb;
  import spq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_LO   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI   = 3'd7;
  localparam int               SETTLE_CYCLES = 24;
  localparam int               HOLD_CYCLES   = 300;
  localparam int               KEY_POOL_N    = 8;
  localparam int               RANDOM_ITEMS  = 36;
  localparam int               NUM_PHASES    = 5;
  localparam int               REPORT_LIMIT  = 10;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
  } queue_cmd_t;

  logic clk_i;
  logic rst_ni;

  spq_item_if   item_ch ();
  spq_result_if result_ch ();
  spq_cfg_if    cfg_ch ();

  stable_priority_queue u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  // predicted queue contents
  logic [KEY_W-1:0]  held_key [DEPTH];
  logic [PRIO_W-1:0] held_prio[DEPTH];
  int                held_count;
  logic [PRIO_W-1:0] append_prio;

  queue_cmd_t        pending_cmds[$];
  result_t           expected_results[$];
  queue_cmd_t        staged_cmd;
  logic [KEY_W-1:0]  key_pool[KEY_POOL_N];

  int item_gap_max;
  int result_stall_max;
  int gap_left;
  int stall_left;
  int hold_left;
  bit pressure_arm;
  bit pressure_done;

  int cmds_issued;
  int cmds_taken;
  int results_seen;
  int dump_entries;
  int full_refusals;
  int delete_misses;
  int settings_tried;
  int fail_count;

  function automatic void post_result(input status_e st, input logic [KEY_W-1:0] k,
                                      input logic [PRIO_W-1:0] p, input logic lst);
    result_t r;
    r.status = st;
    r.key    = k;
    r.prio   = p;
    r.occ    = OCC_W'(held_count);
    r.last   = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void remove_entry(input int pos);
    for (int i = pos; i < held_count - 1; i++) begin
      held_key[i]  = held_key[i+1];
      held_prio[i] = held_prio[i+1];
    end
    held_count--;
  endfunction

  function automatic void predict_queue_op(input queue_cmd_t c);
    int               pos;
    int               hit;
    logic [KEY_W-1:0]  k;
    logic [PRIO_W-1:0] p;
    case (c.cmd)
      CMD_ADD: begin
        if (held_count >= DEPTH) begin
          full_refusals++;
          post_result(STAT_FULL, '0, '0, 1'b1);
        end else begin
          pos = held_count;
          // first entry with a strictly larger priority, unless appending
          if (c.prio != append_prio) begin
            for (int i = held_count - 1; i >= 0; i--) begin
              if (held_prio[i] > c.prio) pos = i;
            end
          end
          for (int i = held_count; i > pos; i--) begin
            held_key[i]  = held_key[i-1];
            held_prio[i] = held_prio[i-1];
          end
          held_key[pos]  = c.key;
          held_prio[pos] = c.prio;
          held_count++;
          post_result(STAT_OK, '0, '0, 1'b1);
        end
      end
      CMD_SERVE, CMD_PEEK: begin
        if (held_count == 0) begin
          post_result(STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          k = held_key[0];
          p = held_prio[0];
          if (c.cmd == CMD_SERVE) remove_entry(0);
          post_result(STAT_OK, k, p, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (held_count == 0) begin
          post_result(STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          hit = -1;
          for (int i = held_count - 1; i >= 0; i--) begin
            if (held_key[i] == c.key) hit = i;
          end
          if (hit < 0) begin
            delete_misses++;
            post_result(STAT_NOT_FOUND, '0, '0, 1'b1);
          end else begin
            k = held_key[hit];
            p = held_prio[hit];
            remove_entry(hit);
            post_result(STAT_OK, k, p, 1'b1);
          end
        end
      end
      CMD_DUMP: begin
        if (held_count == 0) begin
          post_result(STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          dump_entries += held_count;
          for (int i = 0; i < held_count; i++) begin
            post_result(STAT_OK, held_key[i], held_prio[i], i == held_count - 1);
          end
        end
      end
      // count and undefined commands
      default: post_result(STAT_OK, '0, '0, 1'b1);
    endcase
  endfunction

  function automatic queue_cmd_t random_cmd();
    queue_cmd_t c;
    int         roll;
    roll   = $urandom_range(0, 99);
    c.key  = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    c.prio = PRIO_W'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) c.key = KEY_W'($urandom);
    if ($urandom_range(0, 5) == 0) c.prio = append_prio;
    if (roll < 38) c.cmd = CMD_ADD;
    else if (roll < 54) c.cmd = CMD_SERVE;
    else if (roll < 72) c.cmd = CMD_DELETE;
    else if (roll < 80) c.cmd = CMD_PEEK;
    else if (roll < 86) c.cmd = CMD_COUNT;
    else if (roll < 96) c.cmd = CMD_DUMP;
    else if (roll < 98) c.cmd = CMD_RSVD_LO;
    else c.cmd = CMD_RSVD_HI;
    return c;
  endfunction

  task automatic offer_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [PRIO_W-1:0] prio);
    queue_cmd_t c;
    c.cmd  = cmd;
    c.key  = key;
    c.prio = prio;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_for_idle();
    while (!(pending_cmds.size() == 0 && cmds_issued == cmds_taken &&
             expected_results.size() == 0)) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_append_priority(input logic [PRIO_W-1:0] v);
    @(posedge clk_i);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.append_priority <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    append_prio = v;
    settings_tried++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_ch.valid        <= 1'b0;
      item_ch.cmd          <= '0;
      item_ch.key          <= '0;
      item_ch.priority_req <= '0;
      gap_left = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        staged_cmd.cmd  = item_ch.cmd;
        staged_cmd.key  = item_ch.key;
        staged_cmd.prio = item_ch.priority_req;
        predict_queue_op(staged_cmd);
        cmds_taken++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          staged_cmd = pending_cmds.pop_front();
          cmds_issued++;
          item_ch.valid        <= 1'b1;
          item_ch.cmd          <= staged_cmd.cmd;
          item_ch.key          <= staged_cmd.key;
          item_ch.priority_req <= staged_cmd.prio;
          gap_left = $urandom_range(0, item_gap_max);
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
      stall_left    = 0;
      hold_left     = 0;
      pressure_done = 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected transaction: st=%0d key=%h prio=%0d occ=%0d last=%b",
                     result_ch.status, result_ch.out_key, result_ch.out_priority,
                     result_ch.occupancy, result_ch.last);
        end else begin
          if (result_ch.status !== expected_results[0].status ||
              result_ch.out_key !== expected_results[0].key ||
              result_ch.out_priority !== expected_results[0].prio ||
              result_ch.occupancy !== expected_results[0].occ ||
              result_ch.last !== expected_results[0].last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display({"mismatch: got st=%0d key=%h prio=%0d occ=%0d last=%b, ",
                        "expected st=%0d key=%h prio=%0d occ=%0d last=%b"},
                       result_ch.status, result_ch.out_key, result_ch.out_priority,
                       result_ch.occupancy, result_ch.last,
                       expected_results[0].status, expected_results[0].key,
                       expected_results[0].prio, expected_results[0].occ,
                       expected_results[0].last);
          end
          void'(expected_results.pop_front());
        end
        stall_left = $urandom_range(0, result_stall_max);
      end
      if (pressure_arm && !pressure_done) begin
        hold_left     = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int               gap_plan[NUM_PHASES];
    int               stall_plan[NUM_PHASES];
    logic [PRIO_W-1:0] setting;
    gap_plan   = '{8, 0, 8, 0, 3};
    stall_plan = '{8, 0, 0, 8, 8};
    rst_ni                 = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.append_priority = APPEND_PRIO_RESET;
    append_prio      = APPEND_PRIO_RESET;
    held_count       = 0;
    pressure_arm     = 1'b0;
    item_gap_max     = 8;
    result_stall_max = 8;
    cmds_issued      = 0;
    cmds_taken       = 0;
    results_seen     = 0;
    dump_entries     = 0;
    full_refusals    = 0;
    delete_misses    = 0;
    settings_tried   = 0;
    fail_count       = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty queue, count and undefined commands
    offer_cmd(CMD_PEEK, '0, '0);
    offer_cmd(CMD_SERVE, '0, '0);
    offer_cmd(CMD_DELETE, 16'hbeef, '0);
    offer_cmd(CMD_DUMP, '0, '0);
    offer_cmd(CMD_COUNT, '0, '0);
    offer_cmd(CMD_RSVD_LO, 16'hffff, 4'hf);
    offer_cmd(CMD_RSVD_HI, 16'h0000, 4'h0);
    // ordering, ties and the append priority
    offer_cmd(CMD_ADD, 16'h0000, 4'd0);
    offer_cmd(CMD_ADD, 16'hffff, 4'd15);
    offer_cmd(CMD_ADD, 16'h1234, 4'd3);
    offer_cmd(CMD_ADD, 16'h5555, 4'd1);
    offer_cmd(CMD_ADD, 16'haaaa, 4'd15);
    offer_cmd(CMD_ADD, 16'h0f0f, 4'd0);
    offer_cmd(CMD_ADD, 16'h3333, 4'd3);
    offer_cmd(CMD_DUMP, '0, '0);
    offer_cmd(CMD_DELETE, 16'h7777, '0);
    offer_cmd(CMD_DELETE, 16'h1234, '0);
    offer_cmd(CMD_PEEK, '0, '0);
    offer_cmd(CMD_SERVE, '0, '0);
    offer_cmd(CMD_COUNT, '0, '0);
    repeat (4) offer_cmd(CMD_SERVE, '0, '0);
    // lone entry removed by key
    offer_cmd(CMD_DELETE, 16'h3333, '0);
    offer_cmd(CMD_COUNT, '0, '0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_for_idle();
      if (phase == 2) begin
        // stalled receiver while the queue overflows, then a full dump
        item_gap_max     = 0;
        result_stall_max = 0;
        pressure_arm     = 1'b1;
        repeat (DEPTH + 2)
          offer_cmd(CMD_ADD, KEY_W'($urandom), PRIO_W'($urandom_range(0, 15)));
        offer_cmd(CMD_DUMP, '0, '0);
        wait_for_idle();
      end
      case (phase)
        0:       setting = '0;
        1:       setting = '1;
        2:       setting = APPEND_PRIO_RESET;
        default: setting = PRIO_W'($urandom_range(0, 15));
      endcase
      write_append_priority(setting);
      item_gap_max     = gap_plan[phase];
      result_stall_max = stall_plan[phase];
      for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = KEY_W'($urandom);
      repeat (RANDOM_ITEMS) pending_cmds.push_back(random_cmd());
    end
    wait_for_idle();

    $display("covered %0d commands and %0d result transactions, %0d of them dump entries",
             cmds_taken, results_seen, dump_entries);
    $display("%0d adds refused as full, %0d deletes missed, %0d append priority settings",
             full_refusals, delete_misses, settings_tried);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== stable_priority_queue.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_if.sv
rtl/core/spq_ram.sv
rtl/core/spq_ctrl.sv
rtl/core/stable_priority_queue.sv
verif/tb.sv
